@@ rtl/core/hdt_pkg.sv @@
// shared types and constants for the head/tail frame deframer
`timescale 1ns / 1ps
package hdt_pkg;

    // default frame capacity in bytes
    localparam int FRAME_BYTES_DEF = 64;

    // field widths
    localparam int BYTE_W  = 8;
    localparam int WORD_W  = 32;
    localparam int IDX_W   = 6;
    localparam int LEN_W   = 7;
    localparam int OUT_W   = 24;
    localparam int CFG_W   = 32;

    // register reset values
    localparam logic [BYTE_W-1:0] HEAD_RESET = 8'hEE;
    localparam logic [WORD_W-1:0] TAIL_RESET = 32'hFFFC_FFFF;

    // key decode
    localparam int                KEY_BYTE_POS  = 6;
    localparam int                KIND_BYTE_POS = 9;
    localparam logic [BYTE_W-1:0] KIND_RELEASE  = 8'd2;
    localparam logic [BYTE_W-1:0] KEY_OFFSET    = 8'h80;

    // queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_HEAD_BYTE = 1'b0,
        CFG_TAIL_WORD = 1'b1
    } cfg_index_t;

    // classified item passed from front to back
    typedef struct packed {
        logic              stored;
        logic [IDX_W-1:0]  store_index;
        logic              frame_done;
        logic [LEN_W-1:0]  frame_length;
        logic [BYTE_W-1:0] key_byte;
        logic [BYTE_W-1:0] kind_byte;
    } hdt_entry_t;

endpackage

@@ rtl/core/head_tail_frame_deframer_unit.sv @@
// top level of the head/tail frame deframer
// a result is registered in the queue and offered once earlier results have been taken
// throughput: one byte per cycle while the queue has room
// a two-entry queue lets input continue while one result waits at the output
// reset (rst_n low, asynchronous) clears position, window, stored key bytes and queue,
// and loads head_byte 0xEE and tail_word 0xFFFCFFFF
`timescale 1ns / 1ps
module head_tail_frame_deframer_unit
    import hdt_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    // configuration write port
    input  logic              cfg_we,
    input  logic [0:0]        cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    // input stream
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [BYTE_W-1:0] s_axis_tdata,   // [7:0] rx_byte
    // result stream
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // [0] stored, [6:1] store_index, [7] frame_done, [14:8] frame_length,
    // [15] key_valid, [23:16] key_code
    output logic [OUT_W-1:0]  m_axis_tdata
);

    logic       in_accept;
    logic       out_accept;
    hdt_entry_t front_entry;
    hdt_entry_t queue_head;

    assign in_accept  = s_axis_tvalid && s_axis_tready;
    assign out_accept = m_axis_tvalid && m_axis_tready;

    // classify and track the frame
    hdt_front #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (in_accept),
        .rx_byte   (s_axis_tdata),
        .entry     (front_entry)
    );

    // decouple input and output
    hdt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_accept),
        .push_data (front_entry),
        .not_full  (s_axis_tready),
        .pop       (out_accept),
        .not_empty (m_axis_tvalid),
        .head_data (queue_head)
    );

    // decode and pack the result
    hdt_back u_back (
        .entry  (queue_head),
        .result (m_axis_tdata)
    );

    // after an accepted item the output is always valid in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n) in_accept |=> m_axis_tvalid)
        else $error("accepted item did not reach the output");

    // input only stalls while results are pending
    assert property (@(posedge clk) disable iff (!rst_n) !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with empty queue");

    // key event only on a completed frame
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[15]) |-> m_axis_tdata[7])
        else $error("key event without completed frame");

    // index is zero when the byte was not stored
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[6:1] == '0))
        else $error("store index set on unstored byte");

endmodule

@@ rtl/core/hdt_front.sv @@
// front end: head detect, position and tail window tracking, classification
`timescale 1ns / 1ps
module hdt_front
    import hdt_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [0:0]        cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    input  logic              accept,
    input  logic [BYTE_W-1:0] rx_byte,
    output hdt_entry_t        entry
);

    localparam int POS_W = $clog2(FRAME_BYTES + 1);
    localparam logic [POS_W-1:0] POS_MAX  = POS_W'(FRAME_BYTES);
    localparam logic [POS_W-1:0] POS_KEY  = POS_W'(KEY_BYTE_POS);
    localparam logic [POS_W-1:0] POS_KIND = POS_W'(KIND_BYTE_POS);

    logic [BYTE_W-1:0] head_reg;
    logic [WORD_W-1:0] tail_reg;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [WORD_W-1:0] win_reg, win_next;
    logic [BYTE_W-1:0] key_reg, key_next;
    logic [BYTE_W-1:0] kind_reg, kind_next;

    logic              take;
    logic              room;
    logic              hit;
    logic [POS_W-1:0]  pos_inc;
    logic [WORD_W-1:0] win_shift;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= HEAD_RESET;
            tail_reg <= TAIL_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_HEAD_BYTE: head_reg <= cfg_data[BYTE_W-1:0];
                CFG_TAIL_WORD: tail_reg <= cfg_data[WORD_W-1:0];
                default:       head_reg <= head_reg;
            endcase
        end
    end

    // classify the byte and work out the next frame state
    always_comb
    begin
        take      = accept && !((pos_reg == '0) && (rx_byte != head_reg));
        room      = pos_reg < POS_MAX;
        pos_inc   = room ? pos_reg + POS_W'(1) : pos_reg;
        win_shift = {win_reg[WORD_W-BYTE_W-1:0], rx_byte};
        hit       = take && (win_shift == tail_reg);

        key_next  = (take && room && pos_reg == POS_KEY)  ? rx_byte : key_reg;
        kind_next = (take && room && pos_reg == POS_KIND) ? rx_byte : kind_reg;

        pos_next  = pos_reg;
        win_next  = win_reg;
        if (take)
        begin
            pos_next = hit ? '0 : pos_inc;
            win_next = hit ? '0 : win_shift;
        end
    end

    // frame state; only bytes 6 and 9 of the frame are kept
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            win_reg  <= '0;
            key_reg  <= '0;
            kind_reg <= '0;
        end
        else
        begin
            pos_reg  <= pos_next;
            win_reg  <= win_next;
            key_reg  <= key_next;
            kind_reg <= kind_next;
        end
    end

    // item handed to the queue
    always_comb
    begin
        entry              = '0;
        entry.stored       = take && room;
        entry.store_index  = (take && room) ? IDX_W'(pos_reg) : '0;
        entry.frame_done   = hit;
        entry.frame_length = hit ? LEN_W'(pos_inc) : '0;
        entry.key_byte     = key_next;
        entry.kind_byte    = kind_next;
    end

endmodule

@@ rtl/core/hdt_queue.sv @@
// short queue between the front end and the output side
`timescale 1ns / 1ps
module hdt_queue
    import hdt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  hdt_entry_t push_data,
    output logic       not_full,
    input  logic       pop,
    output logic       not_empty,
    output hdt_entry_t head_data
);

    hdt_entry_t         mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_CNT_W-1:0] cnt_reg;

    assign not_full  = cnt_reg != Q_CNT_W'(Q_DEPTH);
    assign not_empty = cnt_reg != '0;
    assign head_data = mem_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0
                                                                   : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0
                                                                   : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

@@ rtl/core/hdt_back.sv @@
// back end: key decode and result packing
`timescale 1ns / 1ps
module hdt_back
    import hdt_pkg::*;
(
    input  hdt_entry_t       entry,
    output logic [OUT_W-1:0] result
);

    logic              key_valid;
    logic [BYTE_W-1:0] key_code;

    // key event on a completed frame with nonzero kind byte
    always_comb
    begin
        key_valid = entry.frame_done && (entry.kind_byte != '0);
        key_code  = '0;
        if (key_valid)
        begin
            key_code = (entry.kind_byte == KIND_RELEASE) ? entry.key_byte + KEY_OFFSET
                                                         : entry.key_byte;
        end
    end

    assign result = {key_code, key_valid, entry.frame_length, entry.frame_done,
                     entry.store_index, entry.stored};

endmodule

@@ tb/sv/testbench.sv @@
// self-checking testbench for the head/tail frame deframer unit
`timescale 1ns / 1ps
module testbench;
    import hdt_pkg::*;

    // one result item, packed as on m_axis_tdata (stored in bit 0)
    typedef struct packed {
        logic [7:0] key_code;
        logic       key_valid;
        logic [6:0] frame_length;
        logic       frame_done;
        logic [5:0] store_index;
        logic       stored;
    } deframe_result_t;

    // one row of the directed stimulus table
    typedef struct {
        logic [7:0]      rx;
        bit              typed;
        deframe_result_t res;
    } stim_row_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [0:0]        cfg_index;
    logic [CFG_W-1:0]  cfg_data;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [BYTE_W-1:0] s_axis_tdata;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [OUT_W-1:0]  m_axis_tdata;

    // predictor copy of registers and state
    logic [7:0]  head_reg;
    logic [31:0] tail_reg;
    logic [6:0]  frame_pos;
    logic [31:0] tail_win;
    logic [7:0]  frame_mem [FRAME_BYTES_DEF];

    deframe_result_t expected_q[$];
    stim_row_t       directed_rows[$];
    deframe_result_t got_res;
    deframe_result_t want_res;

    int  send_idle_pct;
    int  recv_idle_pct;
    bit  hold_req;
    int  hold_left;
    int  items_sent;
    int  frame_items;
    int  results_checked;
    int  mismatches;
    int  frames_closed;
    int  key_frames;
    int  overlong_frames;

    head_tail_frame_deframer_unit uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [7:0] rx_byte
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        // [0] stored, [6:1] store_index, [7] frame_done, [14:8] frame_length,
        // [15] key_valid, [23:16] key_code
        .m_axis_tdata  (m_axis_tdata)
    );

    // clock
    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // run limit
    initial
    begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // deframe one byte: updates the predictor state and returns the result
    function automatic deframe_result_t deframe_byte(logic [7:0] b);
        deframe_result_t r;
        logic [7:0]      k;
        r = '0;
        if (!(frame_pos == 0 && b != head_reg))
        begin
            if (frame_pos < FRAME_BYTES_DEF)
            begin
                frame_mem[frame_pos[5:0]] = b;
                r.stored      = 1'b1;
                r.store_index = frame_pos[5:0];
                frame_pos     = frame_pos + 7'd1;
            end
            tail_win = {tail_win[23:0], b};
            if (tail_win == tail_reg)
            begin
                r.frame_done   = 1'b1;
                r.frame_length = frame_pos;
                tail_win       = '0;
                frame_pos      = '0;
                if (r.frame_length != 0 && frame_mem[KIND_BYTE_POS] != 0)
                begin
                    k = frame_mem[KEY_BYTE_POS];
                    if (frame_mem[KIND_BYTE_POS] == KIND_RELEASE)
                        k = k + KEY_OFFSET;
                    r.key_valid = 1'b1;
                    r.key_code  = k;
                end
            end
        end
        return r;
    endfunction

    function automatic stim_row_t typed_row(logic [7:0] b, int st, int idx, int dn,
                                            int len, int kv, int kc);
        stim_row_t row;
        row.rx                 = b;
        row.typed              = 1'b1;
        row.res.stored         = st[0];
        row.res.store_index    = idx[5:0];
        row.res.frame_done     = dn[0];
        row.res.frame_length   = len[6:0];
        row.res.key_valid      = kv[0];
        row.res.key_code       = kc[7:0];
        return row;
    endfunction

    function automatic stim_row_t open_row(logic [7:0] b);
        stim_row_t row;
        row.rx    = b;
        row.typed = 1'b0;
        row.res   = '0;
        return row;
    endfunction

    // offer one byte, wait for the handshake, record what it should produce
    task automatic send_byte(logic [7:0] b, bit typed, deframe_result_t typed_res);
        deframe_result_t pred;
        bit              in_frame;
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        in_frame = !(frame_pos == 0 && b != head_reg);
        pred = deframe_byte(b);
        expected_q.push_back(typed ? typed_res : pred);
        items_sent++;
        if (in_frame)
            frame_items++;
        if (pred.frame_done)
        begin
            frames_closed++;
            if (pred.key_valid)
                key_frames++;
            if (pred.frame_length == FRAME_BYTES_DEF)
                overlong_frames++;
        end
    endtask

    // head, random payload with a chosen key kind, then optionally the tail
    task automatic send_frame(bit with_tail);
        int         payload_len;
        logic [7:0] b;
        payload_len = ($urandom_range(9) == 0) ? $urandom_range(60, 72)
                                               : $urandom_range(0, 14);
        send_byte(head_reg, 1'b0, '0);
        for (int i = 0; i < payload_len; i++)
        begin
            b = 8'($urandom_range(255));
            // byte 9 selects no key, press, release or any value
            if (i == KIND_BYTE_POS - 1)
            begin
                case ($urandom_range(3))
                    0: b = 8'h00;
                    1: b = 8'h01;
                    2: b = KIND_RELEASE;
                    default: ;
                endcase
            end
            send_byte(b, 1'b0, '0);
        end
        if (with_tail)
            for (int i = 3; i >= 0; i--)
                send_byte(tail_reg[i*8 +: 8], 1'b0, '0);
    endtask

    // stop offering and wait until every result is back
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // one register write, then the write enable is dropped again on the write port
    task automatic write_reg(cfg_index_t idx, logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_HEAD_BYTE)
            head_reg = val[7:0];
        else
            tail_reg = val;
        @(posedge clk);
    endtask

    task automatic check_field(string name, int want, int got);
        if (want != got)
        begin
            mismatches++;
            if (mismatches <= 40)
                $display("%0t ns: %s expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    // receiver: random stalls plus one long hold-off on request
    always @(posedge clk)
    begin
        if (hold_req)
        begin
            hold_left = 48;
            hold_req  = 1'b0;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_res = deframe_result_t'(m_axis_tdata);
            if (expected_q.size() == 0)
            begin
                mismatches++;
                $display("%0t ns: result with none expected, expected none actual %h",
                         $time, m_axis_tdata);
            end
            else
            begin
                want_res = expected_q.pop_front();
                results_checked++;
                check_field("stored", int'(want_res.stored), int'(got_res.stored));
                check_field("store_index", int'(want_res.store_index),
                            int'(got_res.store_index));
                check_field("frame_done", int'(want_res.frame_done),
                            int'(got_res.frame_done));
                check_field("frame_length", int'(want_res.frame_length),
                            int'(got_res.frame_length));
                check_field("key_valid", int'(want_res.key_valid),
                            int'(got_res.key_valid));
                check_field("key_code", int'(want_res.key_code), int'(got_res.key_code));
            end
        end
    end

    // main sequence
    initial
    begin
        logic [7:0]  head_set [6];
        logic [31:0] tail_set [6];
        int          goal;
        int          pick;

        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_HEAD_BYTE;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        hold_req      = 1'b0;
        hold_left     = 0;
        send_idle_pct = 23;
        recv_idle_pct = 60;
        head_reg      = HEAD_RESET;
        tail_reg      = TAIL_RESET;
        frame_pos     = '0;
        tail_win      = '0;
        foreach (frame_mem[i])
            frame_mem[i] = '0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // dropped bytes outside a frame, at both extremes
        directed_rows.push_back(typed_row(8'h00, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(typed_row(8'hFF, 0, 0, 0, 0, 0, 0));
        // short frame after reset: key bytes still zero, so no key
        directed_rows.push_back(typed_row(8'hEE, 1, 0, 0, 0, 0, 0));
        directed_rows.push_back(typed_row(8'hFF, 1, 1, 0, 0, 0, 0));
        directed_rows.push_back(typed_row(8'hFC, 1, 2, 0, 0, 0, 0));
        directed_rows.push_back(typed_row(8'hFF, 1, 3, 0, 0, 0, 0));
        directed_rows.push_back(typed_row(8'hFF, 1, 4, 1, 5, 0, 0));
        // release key whose code wraps past eight bits
        directed_rows.push_back(typed_row(8'hEE, 1, 0, 0, 0, 0, 0));
        directed_rows.push_back(open_row(8'h01));
        directed_rows.push_back(open_row(8'h02));
        directed_rows.push_back(open_row(8'h03));
        directed_rows.push_back(open_row(8'h04));
        directed_rows.push_back(open_row(8'h05));
        directed_rows.push_back(open_row(8'h90));
        directed_rows.push_back(open_row(8'h07));
        directed_rows.push_back(open_row(8'h08));
        directed_rows.push_back(open_row(8'h02));
        directed_rows.push_back(open_row(8'hFF));
        directed_rows.push_back(open_row(8'hFC));
        directed_rows.push_back(open_row(8'hFF));
        directed_rows.push_back(typed_row(8'hFF, 1, 13, 1, 14, 1, 8'h10));
        // short frame reusing key bytes left by the previous frame
        directed_rows.push_back(typed_row(8'hEE, 1, 0, 0, 0, 0, 0));
        directed_rows.push_back(open_row(8'hFF));
        directed_rows.push_back(open_row(8'hFC));
        directed_rows.push_back(open_row(8'hFF));
        directed_rows.push_back(typed_row(8'hFF, 1, 4, 1, 5, 1, 8'h10));

        foreach (directed_rows[i])
            send_byte(directed_rows[i].rx, directed_rows[i].typed, directed_rows[i].res);

        // register settings per random phase, extremes included
        head_set = '{8'hEE, 8'h00, 8'hFF, 8'h55, 8'h00, 8'hEE};
        tail_set = '{32'hFFFC_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0, 32'h0,
                     32'hFFFC_FFFF};
        head_set[4] = 8'($urandom_range(255));
        tail_set[3] = $urandom;
        tail_set[4] = $urandom;

        for (int p = 0; p < 6; p++)
        begin
            drain_results();
            write_reg(CFG_HEAD_BYTE, {24'h0, head_set[p]});
            write_reg(CFG_TAIL_WORD, tail_set[p]);
            send_idle_pct = (p < 2) ? 23 : (p < 4) ? 60 : 0;
            recv_idle_pct = (p < 2) ? 60 : (p < 4) ? 23 : 0;
            // long receiver hold-off while the sender floods the input
            if (p == 4)
                hold_req = 1'b1;
            goal = frame_items + 80;
            while (frame_items < goal)
            begin
                pick = $urandom_range(99);
                if (pick < 75)
                    send_frame(1'b1);
                else if (pick < 85)
                    send_frame(1'b0);
                else
                    send_byte(8'($urandom_range(255)), 1'b0, '0);
            end
        end
        drain_results();

        $display("sent %0d bytes (%0d inside frames) under 6 register settings",
                 items_sent, frame_items);
        $display("checked %0d results: %0d frames closed, %0d with key codes, %0d overlong",
                 results_checked, frames_closed, key_frames, overlong_frames);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
